>>> hdl/dfo_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the depth-first vertex order block.
package dfo_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] KIND_PRE     = 2'd0;
   localparam logic [1:0] KIND_POST    = 2'd1;
   localparam logic [1:0] KIND_REVPOST = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_VERTEX = 2'd2;
   localparam logic [1:0] STATUS_READ   = 2'd3;

   localparam logic       REG_VERTEX_COUNT    = 1'b0;
   localparam logic [8:0] VERTEX_COUNT_RESET  = 9'd256;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] edge_from;
      logic [7:0] edge_to;
      logic [1:0] order_kind;
      logic [7:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] vertex_out;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic       take_item;
      logic       ld_read;
      logic       ld_write;
      logic       run_init;
      logic       clr_vis_step;
      logic       scan_reset;
      logic       scan_rd;
      logic       scan_next;
      logic       enter_from_scan;
      logic       enter_from_w;
      logic       enter_rd;
      logic       enter_set;
      logic       edge_rd;
      logic       edge_take;
      logic       vis_rd;
      logic       pop;
      logic       pop_load;
      logic       run_done;
      logic       rd_issue;
      logic       rd_take;
      logic       clear_graph;
      logic       set_code;
      logic [1:0] code;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] mode;
      logic       ld_bad_vertex;
      logic       ld_full;
      logic       scan_end;
      logic       visited_bit;
      logic       depth_zero;
      logic       depth_one;
      logic       rem_nonzero;
      logic       w_out_range;
      logic       can_push;
      logic       rd_bad;
      logic       rsp_free;
   } sts_type;

endpackage

>>> hdl/dfo_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dfo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dfo_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences load, run, read and clear transactions.
module dfo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfo_pkg::sts_type sts,
   output dfo_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_LD_CHK    = 4'd1;
   localparam logic [3:0] S_LD_WR     = 4'd2;
   localparam logic [3:0] S_RUN_CLR   = 4'd3;
   localparam logic [3:0] S_SCAN_RD   = 4'd4;
   localparam logic [3:0] S_SCAN_CHK  = 4'd5;
   localparam logic [3:0] S_ENTER_RD  = 4'd6;
   localparam logic [3:0] S_ENTER_SET = 4'd7;
   localparam logic [3:0] S_WALK      = 4'd8;
   localparam logic [3:0] S_EDGE_WAIT = 4'd9;
   localparam logic [3:0] S_VIS_RD    = 4'd10;
   localparam logic [3:0] S_VIS_CHK   = 4'd11;
   localparam logic [3:0] S_POP_WAIT  = 4'd12;
   localparam logic [3:0] S_RD_CHK    = 4'd13;
   localparam logic [3:0] S_RD_WAIT   = 4'd14;
   localparam logic [3:0] S_RESP      = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               case (sts.mode)
                  dfo_pkg::MODE_LOAD: state_in = S_LD_CHK;
                  dfo_pkg::MODE_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = S_RUN_CLR;
                  end
                  dfo_pkg::MODE_READ: state_in = S_RD_CHK;
                  default: begin
                     cmd.clear_graph = 1'b1;
                     cmd.set_code    = 1'b1;
                     cmd.code        = dfo_pkg::STATUS_OK;
                     state_in        = S_RESP;
                  end
               endcase
            end
         end
         S_LD_CHK: begin
            if (sts.ld_bad_vertex) begin
               cmd.set_code = 1'b1;
               cmd.code     = dfo_pkg::STATUS_VERTEX;
               state_in     = S_RESP;
            end else if (sts.ld_full) begin
               cmd.set_code = 1'b1;
               cmd.code     = dfo_pkg::STATUS_FULL;
               state_in     = S_RESP;
            end else begin
               cmd.ld_read = 1'b1;
               state_in    = S_LD_WR;
            end
         end
         S_LD_WR: begin
            cmd.ld_write = 1'b1;
            cmd.set_code = 1'b1;
            cmd.code     = dfo_pkg::STATUS_OK;
            state_in     = S_RESP;
         end
         S_RUN_CLR: begin
            if (sts.scan_end) begin
               cmd.scan_reset = 1'b1;
               state_in       = S_SCAN_RD;
            end else begin
               cmd.clr_vis_step = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_end) begin
               cmd.run_done = 1'b1;
               cmd.set_code = 1'b1;
               cmd.code     = dfo_pkg::STATUS_OK;
               state_in     = S_RESP;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (sts.visited_bit) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               cmd.enter_from_scan = 1'b1;
               state_in            = S_ENTER_RD;
            end
         end
         S_ENTER_RD: begin
            cmd.enter_rd = 1'b1;
            state_in     = S_ENTER_SET;
         end
         S_ENTER_SET: begin
            cmd.enter_set = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (sts.depth_zero) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (sts.rem_nonzero) begin
               cmd.edge_rd = 1'b1;
               state_in    = S_EDGE_WAIT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = sts.depth_one ? S_WALK : S_POP_WAIT;
            end
         end
         S_EDGE_WAIT: begin
            cmd.edge_take = 1'b1;
            state_in      = S_VIS_RD;
         end
         S_VIS_RD: begin
            if (sts.w_out_range) begin
               state_in = S_WALK;
            end else begin
               cmd.vis_rd = 1'b1;
               state_in   = S_VIS_CHK;
            end
         end
         S_VIS_CHK: begin
            if (!sts.visited_bit && sts.can_push) begin
               cmd.enter_from_w = 1'b1;
               state_in         = S_ENTER_RD;
            end else begin
               state_in = S_WALK;
            end
         end
         S_POP_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = S_WALK;
         end
         S_RD_CHK: begin
            cmd.set_code = 1'b1;
            if (sts.rd_bad) begin
               cmd.code = dfo_pkg::STATUS_READ;
               state_in = S_RESP;
            end else begin
               cmd.code     = dfo_pkg::STATUS_OK;
               cmd.rd_issue = 1'b1;
               state_in     = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            cmd.rd_take = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dfo_datapath.sv
`timescale 1ns / 1ps
// Datapath: edge lists, walk stack, order stores, counters and result register.
module dfo_datapath #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [8:0]       vertex_count,
   input  dfo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dfo_pkg::rsp_type rsp_data,
   input  dfo_pkg::cmd_type cmd,
   output dfo_pkg::sts_type sts
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int DW  = $clog2(MAX_EDGES + 1);
   localparam int FW  = VW + EW + DW;

   dfo_pkg::req_type item_ff;
   dfo_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic [1:0]       res_status_ff;
   logic [7:0]       res_vout_ff;

   logic [MAX_VERTICES-1:0] deg_valid_ff;
   logic                    deg_vld_rd_ff;
   logic [DW-1:0]           edges_used_ff;
   logic                    result_ready_ff;
   logic [VCW-1:0]          order_filled_ff;
   logic [VCW-1:0]          pre_n_ff;
   logic [VCW-1:0]          post_n_ff;
   logic [VCW-1:0]          scan_ff;
   logic [VCW-1:0]          depth_ff;
   logic [VW-1:0]           new_v_ff;
   logic [VW-1:0]           top_v_ff;
   logic [EW-1:0]           top_cur_ff;
   logic [DW-1:0]           top_rem_ff;
   logic [7:0]              w_ff;

   logic [VCW-1:0] vc_live;
   logic [VW-1:0]  from_idx;
   logic [VW-1:0]  scan_idx;
   logic [VW-1:0]  w_idx;
   logic [EW-1:0]  new_edge;
   logic [DW-1:0]  ld_deg;
   logic [DW-1:0]  en_deg;

   logic [7:0]    target_rd;
   logic [EW-1:0] link_rd;
   logic [EW-1:0] head_rd;
   logic [EW-1:0] tail_rd;
   logic [DW-1:0] deg_rd;
   logic          visited_rd;
   logic [FW-1:0] stack_rd;
   logic [VW-1:0] pre_rd;
   logic [VW-1:0] post_rd;
   logic [VW-1:0] post_addr;

   assign vc_live  = (32'(vertex_count) > MAX_VERTICES) ? VCW'(MAX_VERTICES)
                                                        : VCW'(vertex_count);
   assign from_idx = VW'(item_ff.edge_from);
   assign scan_idx = VW'(scan_ff);
   assign w_idx    = VW'(w_ff);
   assign new_edge = EW'(edges_used_ff);
   assign ld_deg   = deg_vld_rd_ff ? deg_rd : '0;
   assign en_deg   = ld_deg;
   assign post_addr = (item_ff.order_kind == dfo_pkg::KIND_REVPOST)
                    ? VW'(order_filled_ff - VCW'(1) - VCW'(item_ff.position))
                    : VW'(item_ff.position);

   dfo_ram #(.WIDTH(8), .DEPTH(MAX_EDGES)) u_target (
      .clock(clock), .wr_en(cmd.ld_write), .wr_addr(new_edge),
      .wr_data(item_ff.edge_to), .rd_en(cmd.edge_rd), .rd_addr(top_cur_ff),
      .rd_data(target_rd)
   );

   dfo_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link (
      .clock(clock), .wr_en(cmd.ld_write && (ld_deg != '0)), .wr_addr(tail_rd),
      .wr_data(new_edge), .rd_en(cmd.edge_rd), .rd_addr(top_cur_ff),
      .rd_data(link_rd)
   );

   dfo_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
      .clock(clock), .wr_en(cmd.ld_write && (ld_deg == '0)), .wr_addr(from_idx),
      .wr_data(new_edge), .rd_en(cmd.enter_rd), .rd_addr(new_v_ff),
      .rd_data(head_rd)
   );

   dfo_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
      .clock(clock), .wr_en(cmd.ld_write), .wr_addr(from_idx),
      .wr_data(new_edge), .rd_en(cmd.ld_read), .rd_addr(from_idx),
      .rd_data(tail_rd)
   );

   dfo_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree (
      .clock(clock), .wr_en(cmd.ld_write), .wr_addr(from_idx),
      .wr_data(ld_deg + DW'(1)), .rd_en(cmd.ld_read || cmd.enter_rd),
      .rd_addr(cmd.ld_read ? from_idx : new_v_ff), .rd_data(deg_rd)
   );

   dfo_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
      .clock(clock), .wr_en(cmd.clr_vis_step || cmd.enter_rd),
      .wr_addr(cmd.clr_vis_step ? scan_idx : new_v_ff), .wr_data(cmd.enter_rd),
      .rd_en(cmd.scan_rd || cmd.vis_rd), .rd_addr(cmd.scan_rd ? scan_idx : w_idx),
      .rd_data(visited_rd)
   );

   dfo_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(cmd.enter_rd && (depth_ff != '0)),
      .wr_addr(VW'(depth_ff - VCW'(1))), .wr_data({top_v_ff, top_cur_ff, top_rem_ff}),
      .rd_en(cmd.pop && (depth_ff != VCW'(1))), .rd_addr(VW'(depth_ff - VCW'(2))),
      .rd_data(stack_rd)
   );

   dfo_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_pre (
      .clock(clock), .wr_en(cmd.enter_rd), .wr_addr(VW'(pre_n_ff)),
      .wr_data(new_v_ff), .rd_en(cmd.rd_issue), .rd_addr(VW'(item_ff.position)),
      .rd_data(pre_rd)
   );

   dfo_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_post (
      .clock(clock), .wr_en(cmd.pop), .wr_addr(VW'(post_n_ff)),
      .wr_data(top_v_ff), .rd_en(cmd.rd_issue), .rd_addr(post_addr),
      .rd_data(post_rd)
   );

   always_comb begin
      sts               = '0;
      sts.mode          = req_data.mode;
      sts.ld_bad_vertex = (32'(item_ff.edge_from) >= 32'(vc_live))
                       || (32'(item_ff.edge_to) >= 32'(vc_live));
      sts.ld_full       = 32'(edges_used_ff) >= MAX_EDGES;
      sts.scan_end      = scan_ff == vc_live;
      sts.visited_bit   = visited_rd;
      sts.depth_zero    = depth_ff == '0;
      sts.depth_one     = depth_ff == VCW'(1);
      sts.rem_nonzero   = top_rem_ff != '0;
      sts.w_out_range   = 32'(w_ff) >= 32'(vc_live);
      sts.can_push      = 32'(depth_ff) < MAX_VERTICES;
      sts.rd_bad        = !result_ready_ff || (item_ff.order_kind == dfo_pkg::KIND_NONE)
                       || (32'(item_ff.position) >= 32'(order_filled_ff));
      sts.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_valid_ff    <= '0;
         edges_used_ff   <= '0;
         result_ready_ff <= 1'b0;
         order_filled_ff <= '0;
         depth_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.clear_graph) begin
            deg_valid_ff    <= '0;
            edges_used_ff   <= '0;
            result_ready_ff <= 1'b0;
         end
         if (cmd.ld_write) begin
            deg_valid_ff[from_idx] <= 1'b1;
            edges_used_ff          <= edges_used_ff + DW'(1);
         end
         if (cmd.run_init) begin
            depth_ff <= '0;
         end else if (cmd.enter_set) begin
            depth_ff <= depth_ff + VCW'(1);
         end else if (cmd.pop) begin
            depth_ff <= depth_ff - VCW'(1);
         end
         if (cmd.run_done) begin
            order_filled_ff <= pre_n_ff;
            result_ready_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_ff <= req_data;
      end
      if (cmd.ld_read || cmd.enter_rd) begin
         deg_vld_rd_ff <= deg_valid_ff[cmd.ld_read ? from_idx : new_v_ff];
      end
      if (cmd.run_init || cmd.scan_reset) begin
         scan_ff <= '0;
      end else if (cmd.clr_vis_step || cmd.scan_next) begin
         scan_ff <= scan_ff + VCW'(1);
      end
      if (cmd.run_init) begin
         pre_n_ff  <= '0;
         post_n_ff <= '0;
      end else begin
         if (cmd.enter_rd) begin
            pre_n_ff <= pre_n_ff + VCW'(1);
         end
         if (cmd.pop) begin
            post_n_ff <= post_n_ff + VCW'(1);
         end
      end
      if (cmd.enter_from_scan) begin
         new_v_ff <= scan_idx;
      end else if (cmd.enter_from_w) begin
         new_v_ff <= w_idx;
      end
      if (cmd.enter_set) begin
         top_v_ff   <= new_v_ff;
         top_rem_ff <= en_deg;
         top_cur_ff <= (en_deg != '0) ? head_rd : '0;
      end else if (cmd.edge_take) begin
         w_ff <= target_rd;
         if (top_rem_ff > DW'(1)) begin
            top_cur_ff <= link_rd;
         end
         top_rem_ff <= top_rem_ff - DW'(1);
      end else if (cmd.pop_load) begin
         {top_v_ff, top_cur_ff, top_rem_ff} <= stack_rd;
      end
      if (cmd.set_code) begin
         res_status_ff <= cmd.code;
         res_vout_ff   <= '0;
      end else if (cmd.rd_take) begin
         res_vout_ff <= (item_ff.order_kind == dfo_pkg::KIND_PRE) ? 8'(pre_rd)
                                                                  : 8'(post_rd);
      end
      if (cmd.rsp_load) begin
         rsp_ff.status     <= res_status_ff;
         rsp_ff.vertex_out <= res_vout_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/digraph_depth_first_order_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction at a time; a new request can be taken in the cycle after
//   the result is loaded into the output register.
// Reset: synchronous; clears the controller, edge count, degree valid bits and
//   result flags, and sets vertex_count to 256. Visited flags are swept each run.
module digraph_depth_first_order_top #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dfo_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   dfo_pkg::cmd_type cmd;
   dfo_pkg::sts_type sts;
   logic [8:0]       vertex_count_ff;
   logic             csr_write;

   // Register file: one register, vertex_count, at byte address 0.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == dfo_pkg::REG_VERTEX_COUNT)
                     ? 32'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= dfo_pkg::VERTEX_COUNT_RESET;
      end else if (csr_write && (csr_paddr[2] == dfo_pkg::REG_VERTEX_COUNT)) begin
         vertex_count_ff <= csr_pwdata[8:0];
      end
   end

   // Controller drives the sequence; datapath holds all stores and counters.
   dfo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   dfo_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_datapath (
      .clock(clock), .reset(reset), .vertex_count(vertex_count_ff),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data), .cmd(cmd), .sts(sts)
   );

   // Accepting a transaction always drops ready until its result is loaded.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another transaction was in flight");

   // Only a successful read carries a vertex.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != dfo_pkg::STATUS_OK)) |-> (rsp_data.vertex_out == '0))
      else $error("error result carries a nonzero vertex");

   // Acceptance of a request is never followed at once by a newly valid result.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared in the cycle right after acceptance");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the depth-first vertex order block.
module testbench;

   localparam int VMAX      = 256;
   localparam int EMAX      = 1024;
   localparam int STALL_MAX = 50000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dfo_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dfo_pkg::rsp_type rsp_data;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   digraph_depth_first_order_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Shadow graph: each vertex keeps its out-edges in load order.
   logic [7:0] adj_list [VMAX][$];
   int         edge_total;
   int         vtx_limit;           // vertex_count as written
   logic [7:0] pre_seq  [VMAX];
   logic [7:0] post_seq [VMAX];
   int         seq_len;
   bit         seq_valid;

   dfo_pkg::req_type pending_q [$]; // transactions waiting to be driven
   dfo_pkg::rsp_type answer_q  [$]; // expected results, oldest first
   int         errors;
   int         idle_cycles;

   // Walk the graph depth first from every unvisited vertex in order.
   function automatic void walk_graph();
      int  live;
      int  depth;
      int  pre_n;
      int  post_n;
      int  top_v [VMAX];
      int  top_i [VMAX];
      bit  seen [VMAX];
      int  v;
      int  w;
      live  = (vtx_limit > VMAX) ? VMAX : vtx_limit;
      pre_n = 0;
      post_n = 0;
      foreach (seen[k]) seen[k] = 1'b0;
      for (int s = 0; s < live; s++) begin
         if (seen[s]) continue;
         seen[s] = 1'b1;
         pre_seq[pre_n++] = s[7:0];
         top_v[0] = s;
         top_i[0] = 0;
         depth = 1;
         while (depth > 0) begin
            v = top_v[depth-1];
            if (top_i[depth-1] < adj_list[v].size()) begin
               w = adj_list[v][top_i[depth-1]];
               top_i[depth-1]++;
               // skip stale targets beyond the live count
               if (w < live && !seen[w]) begin
                  seen[w] = 1'b1;
                  pre_seq[pre_n++] = w[7:0];
                  top_v[depth] = w;
                  top_i[depth] = 0;
                  depth++;
               end
            end else begin
               post_seq[post_n++] = v[7:0];
               depth--;
            end
         end
      end
      seq_len   = pre_n;
      seq_valid = 1'b1;
   endfunction

   function automatic dfo_pkg::rsp_type predict_answer(dfo_pkg::req_type r);
      dfo_pkg::rsp_type a;
      int      live;
      a = '0;
      live = (vtx_limit > VMAX) ? VMAX : vtx_limit;
      case (r.mode)
         dfo_pkg::MODE_LOAD: begin
            if (r.edge_from >= live || r.edge_to >= live) a.status = dfo_pkg::STATUS_VERTEX;
            else if (edge_total >= EMAX) a.status = dfo_pkg::STATUS_FULL;
            else begin
               adj_list[r.edge_from].push_back(r.edge_to);
               edge_total++;
            end
         end
         dfo_pkg::MODE_RUN: walk_graph();
         dfo_pkg::MODE_READ: begin
            if (!seq_valid || r.order_kind == dfo_pkg::KIND_NONE || r.position >= seq_len)
               a.status = dfo_pkg::STATUS_READ;
            else if (r.order_kind == dfo_pkg::KIND_PRE)
               a.vertex_out = pre_seq[r.position];
            else if (r.order_kind == dfo_pkg::KIND_POST)
               a.vertex_out = post_seq[r.position];
            else a.vertex_out = post_seq[seq_len - 1 - r.position];
         end
         default: begin
            foreach (adj_list[k]) adj_list[k].delete();
            edge_total = 0;
            seq_valid  = 1'b0;
         end
      endcase
      return a;
   endfunction

   // Driver: present one pending transaction at a time, with a random gap ahead.
   int req_gap;
   bit req_calm;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
         req_calm  <= 1'b0;
      end else begin
         if (req_valid && req_ready) answer_q.push_back(predict_answer(req_data));
         if ($urandom_range(0, 99) == 0) req_calm <= !req_calm;
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
               req_gap   <= req_calm ? 0 : $urandom_range(0, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, compare each result with the oldest expectation.
   int rsp_gap;
   bit rsp_calm;
   always @(posedge clock) begin
      dfo_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
         rsp_calm  <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) == 0) rsp_calm <= !rsp_calm;
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.vertex_out !== want.vertex_out) begin
                  $display("%0t: vertex_out expected %0d actual %0d",
                           $time, want.vertex_out, rsp_data.vertex_out);
                  errors++;
               end
            end
            rsp_gap   <= rsp_calm ? 0 : $urandom_range(0, 10);
            rsp_ready <= rsp_calm;
         end else if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= (rsp_gap == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: give up after a long stretch with no transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_MAX) begin
         $display("testbench NOT OK");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic queue_item(logic [1:0] mode, int src, int dst, int kind, int pos);
      dfo_pkg::req_type r;
      r.mode       = mode;
      r.edge_from  = src[7:0];
      r.edge_to    = dst[7:0];
      r.order_kind = kind[1:0];
      r.position   = pos[7:0];
      pending_q.push_back(r);
   endtask

   // Hold until every expected result is back and the block is quiet.
   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || answer_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 3'(4 * dfo_pkg::REG_VERTEX_COUNT);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      vtx_limit = value & 9'h1FF;
      @(posedge clock);
   endtask

   task automatic random_reads(int count, int span);
      repeat (count)
         queue_item(dfo_pkg::MODE_READ, $urandom, $urandom, $urandom_range(0, 3),
                    $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                              : $urandom_range(0, span));
   endtask

   // One graph session: clear, load mostly valid edges, run, read back.
   task automatic graph_session(int vc);
      int n_edges;
      int hi;
      write_vertex_count(vc);
      hi = (vc > 256) ? 255 : (vc == 0 ? 0 : vc - 1);
      queue_item(dfo_pkg::MODE_CLEAR, 0, 0, 0, 0);
      if ($urandom_range(0, 3) == 0) random_reads(2, hi);
      n_edges = $urandom_range(0, 2 * (hi + 1));
      repeat (n_edges) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(dfo_pkg::MODE_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom, $urandom);
         else
            queue_item(dfo_pkg::MODE_LOAD, $urandom_range(0, hi), $urandom_range(0, hi),
                       $urandom, $urandom);
      end
      queue_item(dfo_pkg::MODE_RUN, $urandom, $urandom, $urandom, $urandom);
      random_reads($urandom_range(4, 12), hi);
      if ($urandom_range(0, 2) == 0) begin
         // append an edge and rerun on the same graph
         queue_item(dfo_pkg::MODE_LOAD, $urandom_range(0, hi), $urandom_range(0, hi), 0, 0);
         queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
         random_reads(4, hi);
      end
      if ($urandom_range(0, 4) == 0) queue_item(dfo_pkg::MODE_CLEAR, 0, 0, 0, 0);
      if ($urandom_range(0, 4) == 0)
         queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 0);
   endtask

   initial begin
      int sent;
      errors     = 0;
      edge_total = 0;
      vtx_limit  = int'(dfo_pkg::VERTEX_COUNT_RESET);
      seq_len    = 0;
      seq_valid  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads before any run, extreme endpoints, every order kind.
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_REVPOST, 0);
      queue_item(dfo_pkg::MODE_LOAD, 0, 255, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 255, 0, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 255, 255, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 0, 7, 0, 0);
      queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 255);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_POST, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_REVPOST, 255);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_NONE, 0);
      queue_item(dfo_pkg::MODE_CLEAR, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_POST, 0);
      drain();

      // Stale edges: load at sixteen vertices, then lower the count.
      write_vertex_count(16);
      queue_item(dfo_pkg::MODE_LOAD, 3, 15, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 3, 2, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 12, 1, 0, 0);
      queue_item(dfo_pkg::MODE_LOAD, 16, 0, 0, 0);
      write_vertex_count(8);
      queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_POST, 7);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 8);
      // A register write leaves the recorded orders readable.
      write_vertex_count(1);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_REVPOST, 3);
      queue_item(dfo_pkg::MODE_LOAD, 0, 1, 0, 0);
      write_vertex_count(0);
      queue_item(dfo_pkg::MODE_LOAD, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
      queue_item(dfo_pkg::MODE_READ, 0, 0, dfo_pkg::KIND_PRE, 0);

      // Fill the edge store past capacity on the full vertex range.
      write_vertex_count(511);
      queue_item(dfo_pkg::MODE_CLEAR, 0, 0, 0, 0);
      repeat (EMAX + 6)
         queue_item(dfo_pkg::MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
      queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
      random_reads(40, 255);
      write_vertex_count(256);
      queue_item(dfo_pkg::MODE_RUN, 0, 0, 0, 0);
      random_reads(10, 255);
      sent = 1110;

      // Random sessions, mostly small graphs.
      while (sent < 1500) begin
         case ($urandom_range(0, 9))
            0:       graph_session($urandom_range(0, 511));
            1:       graph_session(1);
            2:       graph_session(256);
            default: graph_session($urandom_range(2, 24));
         endcase
         sent += pending_q.size();
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && answer_q.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
